>>> rtl/dmc_pkg.sv
// Package for the depth mask centroid block: widths, limits, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package dmc_pkg;

  localparam int unsigned DepthW = 16;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned SumW   = 30;
  localparam int unsigned CntW   = 21;
  localparam int unsigned LimW   = 13;

  localparam logic [LimW-1:0] MaxRows    = LimW'(1024);
  localparam logic [LimW-1:0] MaxCols    = LimW'(1024);
  localparam logic [CntW-1:0] FgCountCap = CntW'(1 << 20);

  localparam int unsigned DivSteps = IdxW;
  localparam int unsigned StepW    = 4;
  localparam logic [StepW-1:0] DivStepInit = StepW'(DivSteps - 1);

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StEmit
  } dmc_state_e;

  typedef struct packed {
    logic take;
    logic div_step;
    logic emit;
  } dmc_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic div_req;
    logic div_done;
  } dmc_sts_t;

endpackage

>>> rtl/dmc_if.sv
// Valid/ready channel interfaces for pixels in and results out.
// Depends on dmc_pkg for field widths.
interface dmc_pix_if;
  import dmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DepthW-1:0] pixel_depth;
  logic [IdxW-1:0]   pixel_row;
  logic [IdxW-1:0]   pixel_col;
  logic              frame_last;

  modport source (output valid, pixel_depth, pixel_row, pixel_col, frame_last,
                  input ready);
  modport sink   (input valid, pixel_depth, pixel_row, pixel_col, frame_last,
                  output ready);
endinterface

interface dmc_res_if;
  import dmc_pkg::*;
  logic            valid;
  logic            ready;
  logic            foreground;
  logic            centroid_valid;
  logic [IdxW-1:0] center_row;
  logic [IdxW-1:0] center_col;

  modport source (output valid, foreground, centroid_valid, center_row, center_col,
                  input ready);
  modport sink   (input valid, foreground, centroid_valid, center_row, center_col,
                  output ready);
endinterface

>>> rtl/dmc_ctrl.sv
// Controller for the depth mask centroid block: accept, divide, emit.
// Depends on dmc_pkg.
module dmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_valid_i,
  output logic              pix_ready_o,
  input  dmc_pkg::dmc_sts_t sts_i,
  output dmc_pkg::dmc_cmd_t cmd_o,
  output dmc_pkg::dmc_state_e state_o
);
  import dmc_pkg::*;

  dmc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.take && sts_i.div_req) begin
          state_d = StDivide;
        end
      end
      StDivide: begin
        if (sts_i.div_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.slot_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    pix_ready_o    = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      StIdle: begin
        pix_ready_o = sts_i.slot_free;
        cmd_o.take  = pix_valid_i && sts_i.slot_free;
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
      end
      StEmit: begin
        cmd_o.emit = sts_i.slot_free;
      end
      default: begin
        pix_ready_o = 1'b0;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

>>> rtl/dmc_datapath.sv
// Datapath: threshold register, accumulators, shared restoring divider
// and the result register. Depends on dmc_pkg.
module dmc_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [dmc_pkg::DepthW-1:0] cfg_wdata_i,
  input  logic [dmc_pkg::DepthW-1:0] pixel_depth_i,
  input  logic [dmc_pkg::IdxW-1:0] pixel_row_i,
  input  logic [dmc_pkg::IdxW-1:0] pixel_col_i,
  input  logic                     frame_last_i,
  input  dmc_pkg::dmc_cmd_t        cmd_i,
  output dmc_pkg::dmc_sts_t        sts_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic                     foreground_o,
  output logic                     centroid_valid_o,
  output logic [dmc_pkg::IdxW-1:0] center_row_o,
  output logic [dmc_pkg::IdxW-1:0] center_col_o
);
  import dmc_pkg::*;

  logic [DepthW-1:0] thresh_q;
  logic [SumW-1:0]   row_sum_q, col_sum_q, row_sum_d, col_sum_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   held_row_q, held_col_q;
  logic              out_valid_q;

  logic [SumW-1:0]   rem_row_q, rem_col_q, dsh_q;
  logic [IdxW-1:0]   quo_row_q, quo_col_q;
  logic [StepW-1:0]  step_q;
  logic              fg_pend_q;
  logic              out_fg_q, out_cv_q;
  logic [IdxW-1:0]   out_row_q, out_col_q;

  logic fg, inc, row_ge, col_ge, load_pix;
  logic [IdxW-1:0] quo_row_nx, quo_col_nx;

  assign fg  = pixel_depth_i <= thresh_q;
  assign inc = fg && ({{(LimW-IdxW){1'b0}}, pixel_row_i} < MaxRows)
                  && ({{(LimW-IdxW){1'b0}}, pixel_col_i} < MaxCols)
                  && (cnt_q < FgCountCap);

  assign row_sum_d = inc ? row_sum_q + {{(SumW-IdxW){1'b0}}, pixel_row_i} : row_sum_q;
  assign col_sum_d = inc ? col_sum_q + {{(SumW-IdxW){1'b0}}, pixel_col_i} : col_sum_q;
  assign cnt_d     = inc ? cnt_q + CntW'(1) : cnt_q;

  assign row_ge     = rem_row_q >= dsh_q;
  assign col_ge     = rem_col_q >= dsh_q;
  assign quo_row_nx = {quo_row_q[IdxW-2:0], row_ge};
  assign quo_col_nx = {quo_col_q[IdxW-2:0], col_ge};

  assign sts_o.slot_free = !out_valid_q || res_ready_i;
  assign sts_o.div_req   = frame_last_i && (cnt_d != '0);
  assign sts_o.div_done  = step_q == '0;

  assign load_pix = cmd_i.take && !sts_o.div_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= '0;
      row_sum_q   <= '0;
      col_sum_q   <= '0;
      cnt_q       <= '0;
      held_row_q  <= '0;
      held_col_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (cmd_i.take) begin
        if (frame_last_i) begin
          row_sum_q <= '0;
          col_sum_q <= '0;
          cnt_q     <= '0;
        end else begin
          row_sum_q <= row_sum_d;
          col_sum_q <= col_sum_d;
          cnt_q     <= cnt_d;
        end
      end
      if (cmd_i.div_step && sts_o.div_done) begin
        held_row_q <= quo_row_nx;
        held_col_q <= quo_col_nx;
      end
      if (load_pix || cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && sts_o.div_req) begin
      rem_row_q <= row_sum_d;
      rem_col_q <= col_sum_d;
      dsh_q     <= {cnt_d, {(SumW-CntW){1'b0}}};
      step_q    <= DivStepInit;
      fg_pend_q <= fg;
    end else if (cmd_i.div_step) begin
      if (row_ge) begin
        rem_row_q <= rem_row_q - dsh_q;
      end
      if (col_ge) begin
        rem_col_q <= rem_col_q - dsh_q;
      end
      quo_row_q <= quo_row_nx;
      quo_col_q <= quo_col_nx;
      dsh_q     <= dsh_q >> 1;
      step_q    <= step_q - StepW'(1);
    end
    if (load_pix) begin
      out_fg_q  <= fg;
      out_cv_q  <= 1'b0;
      out_row_q <= held_row_q;
      out_col_q <= held_col_q;
    end else if (cmd_i.emit) begin
      out_fg_q  <= fg_pend_q;
      out_cv_q  <= 1'b1;
      out_row_q <= held_row_q;
      out_col_q <= held_col_q;
    end
  end

  assign res_valid_o      = out_valid_q;
  assign foreground_o     = out_fg_q;
  assign centroid_valid_o = out_cv_q;
  assign center_row_o     = out_row_q;
  assign center_col_o     = out_col_q;

endmodule

>>> rtl/depth_mask_centroid_core.sv
// Depth mask centroid: one result per depth pixel, centroid at frame end.
// Channels: pix_i takes a pixel transaction (depth, row, col, frame_last);
// res_o gives one result transaction per pixel (foreground, centroid_valid,
// held center row/col). Both are valid/ready channels.
// Configuration: cfg_we_i writes cfg_wdata_i into the depth threshold.
// A pixel with depth at or below the threshold is foreground; its row and
// column are summed and counted.
// Flow: an ordinary pixel's result is registered and appears in the cycle
// after acceptance, and a new pixel is taken each cycle while res_o drains
// (one per cycle). A frame-last pixel whose frame had foreground runs the
// restoring divider (one quotient bit per cycle for row and column together),
// then waits in the emit state until res_o has room before its result is
// registered; pixels are not taken meanwhile.
// Reset clears threshold, sums, count and held centroid, and empties res_o.
// When the receiver stalls, the result register holds and pix_i.ready drops.
// Depends on dmc_pkg, dmc_if, dmc_ctrl and dmc_datapath.
module depth_mask_centroid_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dmc_pkg::DepthW-1:0] cfg_wdata_i,
  dmc_pix_if.sink                    pix_i,
  dmc_res_if.source                  res_o
);
  import dmc_pkg::*;

  dmc_cmd_t   cmd;
  dmc_sts_t   sts;
  dmc_state_e state;

  dmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  dmc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pixel_depth_i    (pix_i.pixel_depth),
    .pixel_row_i      (pix_i.pixel_row),
    .pixel_col_i      (pix_i.pixel_col),
    .frame_last_i     (pix_i.frame_last),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .res_valid_o      (res_o.valid),
    .res_ready_i      (res_o.ready),
    .foreground_o     (res_o.foreground),
    .centroid_valid_o (res_o.centroid_valid),
    .center_row_o     (res_o.center_row),
    .center_col_o     (res_o.center_col)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state != StIdle) |-> !pix_i.ready)
    else $error("pixel ready outside idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take && sts.div_req) |=> (state == StDivide))
    else $error("frame end with foreground did not start divide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit) |=> (res_o.valid && res_o.centroid_valid))
    else $error("emit did not present a valid centroid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == StDivide) |=> !(res_o.valid && $rose(res_o.valid) && !res_o.centroid_valid))
    else $error("pixel result issued during divide");
`endif

endmodule
